// ===== sv/gdtq_pkg.sv =====
// Package: shared types, operation and result codes for the grouped deadline timer queue.
`default_nettype none
package gdtq_pkg;
  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    OP_ADD_AUTO  = 3'd0,
    OP_ADD_GIVEN = 3'd1,
    OP_REPLACE   = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_REM_GROUP = 3'd4,
    OP_TICK      = 3'd5
  } op_t;

  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_REMOVED  = 2'd2;
  localparam logic [1:0] KIND_EXPIRED  = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] group_id;
    logic [31:0] timer_id;
    logic [31:0] timeout;
    logic [15:0] job_tag;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_ADD,
    ST_SCAN,
    ST_EMIT,
    ST_OUT
  } bst_t;
endpackage
`default_nettype wire

// ===== sv/grouped_deadline_timer_queue.sv =====
// Top level: grouped deadline timer queue, front decode queue plus table engine.
// Add writes the first free slot. Remove scans every slot; replace then adds after its remove result.
// Tick runs the one-slot-per-cycle deadline scan once per expiry, earliest deadline first;
// a tick with nothing expired gives no result.
// One operation is executed at a time; the front queue holds two more.
// Synchronous active-low reset clears slot valid bits, time and the id counter.
`default_nettype none
module grouped_deadline_timer_queue #(
  parameter int CAPACITY = gdtq_pkg::CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_group_id,
  input  wire logic [31:0] in_timer_id,
  input  wire logic [31:0] in_timeout,
  input  wire logic [15:0] in_job_tag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_out_group,
  output logic [31:0]      out_out_timer,
  output logic [15:0]      out_out_tag,
  output logic [4:0]       out_removed_count,
  output logic             out_last
);
  import gdtq_pkg::*;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  gdtq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_group_id,
    .in_timer_id, .in_timeout, .in_job_tag, .q_valid, .q_cmd, .q_pop
  );

  gdtq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_stall,
    .out_kind, .out_out_group, .out_out_timer, .out_out_tag,
    .out_removed_count, .out_last
  );
endmodule
`default_nettype wire

// ===== sv/gdtq_front.sv =====
// Front end: accepts operations, drops unknown codes, assigns automatic ids, queues commands.
`default_nettype none
module gdtq_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      in_operation,
  input  wire logic [31:0]     in_group_id,
  input  wire logic [31:0]     in_timer_id,
  input  wire logic [31:0]     in_timeout,
  input  wire logic [15:0]     in_job_tag,
  output logic                 q_valid,
  output gdtq_pkg::cmd_t       q_cmd,
  input  wire logic            q_pop
);
  import gdtq_pkg::*;
  localparam int QD = 2;
  cmd_t         mem_r [QD];
  logic         wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [31:0]  next_id_r, next_id_nxt;
  logic         acc, push;
  cmd_t         cmd;

  assign in_stall = (cnt_r == 2'(QD));
  assign acc = in_valid && !in_stall;
  assign push = acc && (in_operation <= 3'(OP_TICK));
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    cmd.operation = in_operation;
    cmd.group_id = in_group_id;
    cmd.timer_id = (in_operation == 3'(OP_ADD_AUTO)) ? next_id_r : in_timer_id;
    cmd.timeout = in_timeout;
    cmd.job_tag = in_job_tag;
    next_id_nxt = next_id_r;
    if (acc && in_operation == 3'(OP_ADD_AUTO)) begin
      next_id_nxt = next_id_r + 32'd1;
    end
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      next_id_r <= 32'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
      next_id_r <= next_id_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
  end
endmodule
`default_nettype wire

// ===== sv/gdtq_back.sv =====
// Back end: holds the timer table and executes queued commands, one result per transfer.
`default_nettype none
module gdtq_back #(
  parameter int CAPACITY = gdtq_pkg::CAPACITY_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  gdtq_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           out_kind,
  output logic [31:0]          out_out_group,
  output logic [31:0]          out_out_timer,
  output logic [15:0]          out_out_tag,
  output logic [4:0]           out_removed_count,
  output logic                 out_last
);
  import gdtq_pkg::*;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);

  bst_t state_r, state_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [63:0] dl_r [CAPACITY];
  logic [31:0] tm_r [CAPACITY];
  logic [31:0] gr_r [CAPACITY];
  logic [15:0] tg_r [CAPACITY];
  logic [63:0] now_r, now_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic best_ok_r, best_ok_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] nres_r, nres_nxt;
  logic after_add_r, after_add_nxt;
  logic wr_en;
  logic [IW-1:0] wr_idx;
  logic [1:0] o_kind_r, o_kind_nxt;
  logic [31:0] o_grp_r, o_grp_nxt, o_tmr_r, o_tmr_nxt;
  logic [15:0] o_tag_r, o_tag_nxt;
  logic [4:0] o_cnt_r, o_cnt_nxt;
  logic o_last_r, o_last_nxt;
  logic free_found;
  logic [IW-1:0] free_idx;
  logic last_idx;

  assign out_valid = (state_r == ST_OUT);
  assign out_kind = o_kind_r;
  assign out_out_group = o_grp_r;
  assign out_out_timer = o_tmr_r;
  assign out_out_tag = o_tag_r;
  assign out_removed_count = o_cnt_r;
  assign out_last = o_last_r;
  assign last_idx = (idx_r == IW'(CAPACITY - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    now_nxt = now_r;
    cmd_nxt = cmd_r;
    idx_nxt = idx_r;
    best_nxt = best_r;
    best_ok_nxt = best_ok_r;
    cnt_nxt = cnt_r;
    nres_nxt = nres_r;
    after_add_nxt = after_add_r;
    o_kind_nxt = o_kind_r;
    o_grp_nxt = o_grp_r;
    o_tmr_nxt = o_tmr_r;
    o_tag_nxt = o_tag_r;
    o_cnt_nxt = o_cnt_r;
    o_last_nxt = o_last_r;
    q_pop = 1'b0;
    wr_en = 1'b0;
    wr_idx = free_idx;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cmd_nxt = q_cmd;
          idx_nxt = '0;
          cnt_nxt = '0;
          nres_nxt = '0;
          best_ok_nxt = 1'b0;
          case (q_cmd.operation)
            3'(OP_ADD_AUTO), 3'(OP_ADD_GIVEN): state_nxt = ST_ADD;
            3'(OP_REPLACE), 3'(OP_REMOVE), 3'(OP_REM_GROUP): state_nxt = ST_REMOVE;
            3'(OP_TICK): begin
              now_nxt = now_r + 64'd1;
              state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_REMOVE: begin
        if (cmd_r.operation == 3'(OP_REM_GROUP)) begin
          if (valid_r[idx_r] && gr_r[idx_r] == cmd_r.group_id) begin
            valid_nxt[idx_r] = 1'b0;
            cnt_nxt = cnt_r + CW'(1);
          end
        end else if (cnt_r == '0 && valid_r[idx_r] && gr_r[idx_r] == cmd_r.group_id &&
                     tm_r[idx_r] == cmd_r.timer_id) begin
          valid_nxt[idx_r] = 1'b0;
          cnt_nxt = CW'(1);
        end
        idx_nxt = idx_r + IW'(1);
        if (last_idx) begin
          o_kind_nxt = KIND_REMOVED;
          o_grp_nxt = cmd_r.group_id;
          o_tmr_nxt = (cmd_r.operation == 3'(OP_REM_GROUP)) ? 32'd0 : cmd_r.timer_id;
          o_tag_nxt = 16'd0;
          o_cnt_nxt = 5'(cnt_nxt);
          o_last_nxt = (cmd_r.operation != 3'(OP_REPLACE));
          after_add_nxt = (cmd_r.operation == 3'(OP_REPLACE));
          state_nxt = ST_OUT;
        end
      end
      ST_ADD: begin
        after_add_nxt = 1'b0;
        o_grp_nxt = cmd_r.group_id;
        o_tmr_nxt = cmd_r.timer_id;
        o_tag_nxt = 16'd0;
        o_cnt_nxt = 5'd0;
        o_last_nxt = 1'b1;
        if (free_found) begin
          wr_en = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          o_kind_nxt = KIND_ADD_OK;
        end else begin
          o_kind_nxt = KIND_ADD_FULL;
        end
        state_nxt = ST_OUT;
      end
      ST_SCAN: begin
        if (valid_r[idx_r] && dl_r[idx_r] <= now_r) begin
          cnt_nxt = cnt_r + CW'(1);
          if (!best_ok_r || dl_r[idx_r] < dl_r[best_r]) begin
            best_nxt = idx_r;
            best_ok_nxt = 1'b1;
          end
        end
        idx_nxt = idx_r + IW'(1);
        if (last_idx) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!best_ok_r) begin
          state_nxt = ST_IDLE;
        end else begin
          valid_nxt[best_r] = 1'b0;
          o_kind_nxt = KIND_EXPIRED;
          o_grp_nxt = gr_r[best_r];
          o_tmr_nxt = tm_r[best_r];
          o_tag_nxt = tg_r[best_r];
          o_cnt_nxt = 5'd0;
          o_last_nxt = (cnt_r == CW'(1)) || (nres_r == RW'(MAX_RESULTS - 1));
          nres_nxt = nres_r + RW'(1);
          idx_nxt = '0;
          cnt_nxt = '0;
          best_ok_nxt = 1'b0;
          after_add_nxt = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (after_add_r) begin
            state_nxt = ST_ADD;
          end else if (o_kind_r == KIND_EXPIRED && !o_last_r) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      now_r <= 64'd0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      now_r <= now_nxt;
    end
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    best_r <= best_nxt;
    best_ok_r <= best_ok_nxt;
    cnt_r <= cnt_nxt;
    nres_r <= nres_nxt;
    after_add_r <= after_add_nxt;
    o_kind_r <= o_kind_nxt;
    o_grp_r <= o_grp_nxt;
    o_tmr_r <= o_tmr_nxt;
    o_tag_r <= o_tag_nxt;
    o_cnt_r <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
    if (wr_en) begin
      dl_r[wr_idx] <= now_r + {32'd0, cmd_r.timeout};
      tm_r[wr_idx] <= cmd_r.timer_id;
      gr_r[wr_idx] <= cmd_r.group_id;
      tg_r[wr_idx] <= cmd_r.job_tag;
    end
  end
endmodule
`default_nettype wire

// ===== verif/tb_grouped_deadline_timer_queue.sv =====
// Testbench for the grouped deadline timer queue: random and directed operations checked against a local predictor.
`timescale 1ns / 1ps
module tb_grouped_deadline_timer_queue;
  import gdtq_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int DRAIN_CYCLES = 2000;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] grp;
    logic [31:0] tmr;
    logic [15:0] tag;
    logic [4:0]  cnt;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic [31:0] in_group_id = '0;
  logic [31:0] in_timer_id = '0;
  logic [31:0] in_timeout = '0;
  logic [15:0] in_job_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [31:0] out_out_group;
  logic [31:0] out_out_timer;
  logic [15:0] out_out_tag;
  logic [4:0] out_removed_count;
  logic out_last;

  grouped_deadline_timer_queue dut (.*);

  always #5 clk = ~clk;

  cmd_t pending_cmds[$];
  result_t expected_results[$];

  logic        tbl_valid[SLOTS];
  logic [63:0] tbl_deadline[SLOTS];
  logic [31:0] tbl_timer[SLOTS];
  logic [31:0] tbl_group[SLOTS];
  logic [15:0] tbl_tag[SLOTS];
  logic [63:0] now_ticks = '0;
  logic [31:0] auto_id = '0;

  int errors = 0;
  int transfers_in = 0;
  int transfers_out = 0;
  int expiries = 0;
  int full_rejects = 0;
  int idle_cycles = 0;
  bit idle_free = 1'b0;
  bit hold_input = 1'b0;
  bit inputs_done = 1'b0;
  bit in_taken = 1'b0;

  function automatic result_t mk(logic [1:0] kind, logic [31:0] grp, logic [31:0] tmr,
                                 logic [15:0] tag, logic [4:0] cnt);
    result_t r;
    r.kind = kind;
    r.grp = grp;
    r.tmr = tmr;
    r.tag = tag;
    r.cnt = cnt;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic result_t table_add(logic [31:0] grp, logic [31:0] id, logic [31:0] tmo,
                                        logic [15:0] tag);
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_deadline[i] = now_ticks + {32'd0, tmo};
        tbl_timer[i] = id;
        tbl_group[i] = grp;
        tbl_tag[i] = tag;
        return mk(KIND_ADD_OK, grp, id, '0, '0);
      end
    end
    return mk(KIND_ADD_FULL, grp, id, '0, '0);
  endfunction

  function automatic result_t table_remove_one(logic [31:0] grp, logic [31:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_timer[i] == id && tbl_group[i] == grp) begin
        tbl_valid[i] = 1'b0;
        return mk(KIND_REMOVED, grp, id, '0, 5'd1);
      end
    end
    return mk(KIND_REMOVED, grp, id, '0, '0);
  endfunction

  task automatic predict_timer_events(input cmd_t c);
    result_t batch[$];
    int best;
    logic [4:0] cnt;
    case (c.operation)
      OP_ADD_AUTO: begin
        batch.insert(batch.size(), table_add(c.group_id, auto_id, c.timeout, c.job_tag));
        auto_id = auto_id + 32'd1;
      end
      OP_ADD_GIVEN: batch.insert(batch.size(),
                                 table_add(c.group_id, c.timer_id, c.timeout, c.job_tag));
      OP_REPLACE: begin
        batch.insert(batch.size(), table_remove_one(c.group_id, c.timer_id));
        batch.insert(batch.size(), table_add(c.group_id, c.timer_id, c.timeout, c.job_tag));
      end
      OP_REMOVE: batch.insert(batch.size(), table_remove_one(c.group_id, c.timer_id));
      OP_REM_GROUP: begin
        cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_group[i] == c.group_id) begin
            tbl_valid[i] = 1'b0;
            cnt++;
          end
        end
        batch.insert(batch.size(), mk(KIND_REMOVED, c.group_id, '0, '0, cnt));
      end
      OP_TICK: begin
        now_ticks = now_ticks + 64'd1;
        while (batch.size() < MAX_RESULTS) begin
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_deadline[i] <= now_ticks &&
                (best < 0 || tbl_deadline[i] < tbl_deadline[best])) best = i;
          end
          if (best < 0) break;
          tbl_valid[best] = 1'b0;
          batch.insert(batch.size(), mk(KIND_EXPIRED, tbl_group[best], tbl_timer[best],
                                        tbl_tag[best], '0));
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_results.insert(expected_results.size(), batch[i]);
  endtask

  function automatic cmd_t mk_cmd(logic [2:0] op, logic [31:0] grp, logic [31:0] id,
                                  logic [31:0] tmo, logic [15:0] tag);
    cmd_t c;
    c.operation = op;
    c.group_id = grp;
    c.timer_id = id;
    c.timeout = tmo;
    c.job_tag = tag;
    return c;
  endfunction

  function automatic void enqueue_cmd(cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic cmd_t random_cmd();
    logic [31:0] grp;
    logic [31:0] id;
    logic [31:0] tmo;
    int r;
    grp = $urandom_range(0, 3);
    id = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) grp = $urandom;
    if ($urandom_range(0, 9) == 0) id = $urandom;
    r = $urandom_range(0, 19);
    if (r < 14) tmo = $urandom_range(0, 6);
    else if (r < 18) tmo = $urandom_range(0, 40);
    else tmo = $urandom;
    r = $urandom_range(0, 99);
    if (r < 25) return mk_cmd(OP_ADD_AUTO, grp, $urandom, tmo, $urandom);
    if (r < 40) return mk_cmd(OP_ADD_GIVEN, grp, id, tmo, $urandom);
    if (r < 50) return mk_cmd(OP_REPLACE, grp, id, tmo, $urandom);
    if (r < 60) return mk_cmd(OP_REMOVE, grp, id, $urandom, $urandom);
    if (r < 65) return mk_cmd(OP_REM_GROUP, grp, $urandom, $urandom, $urandom);
    if (r < 97) return mk_cmd(OP_TICK, $urandom, $urandom, $urandom, $urandom);
    return mk_cmd(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    // Directed: extremes, full table, duplicate ids, many expiries in one tick.
    enqueue_cmd(mk_cmd(OP_TICK, '0, '0, '0, '0));
    enqueue_cmd(mk_cmd(OP_ADD_AUTO, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 16'hFFFF));
    enqueue_cmd(mk_cmd(OP_ADD_GIVEN, '0, 32'hFFFF_FFFF, '0, '0));
    enqueue_cmd(mk_cmd(OP_ADD_GIVEN, 32'd7, 32'd5, 32'd2, 16'h1234));
    enqueue_cmd(mk_cmd(OP_ADD_GIVEN, 32'd7, 32'd5, 32'd1, 16'h4321));
    enqueue_cmd(mk_cmd(OP_REMOVE, 32'd7, 32'd5, '0, '0));
    enqueue_cmd(mk_cmd(OP_REMOVE, 32'd8, 32'd5, '0, '0));
    enqueue_cmd(mk_cmd(OP_REPLACE, 32'd7, 32'd5, 32'd3, 16'hAAAA));
    enqueue_cmd(mk_cmd(OP_REPLACE, 32'd9, 32'd6, 32'd1, 16'h5555));
    for (int i = 0; i < 12; i++)
      enqueue_cmd(mk_cmd(OP_ADD_AUTO, 32'd3, '0, 32'd2, 16'(i)));
    enqueue_cmd(mk_cmd(OP_ADD_AUTO, 32'd3, '0, '0, '0));
    enqueue_cmd(mk_cmd(OP_ADD_GIVEN, 32'd3, 32'd1, '0, '0));
    enqueue_cmd(mk_cmd(3'd6, '1, '1, '1, '1));
    enqueue_cmd(mk_cmd(3'd7, '0, '0, '0, '0));
    enqueue_cmd(mk_cmd(OP_TICK, '0, '0, '0, '0));
    enqueue_cmd(mk_cmd(OP_TICK, '0, '0, '0, '0));
    enqueue_cmd(mk_cmd(OP_REM_GROUP, 32'hFFFF_FFFF, '1, '0, '0));
    enqueue_cmd(mk_cmd(OP_REM_GROUP, '0, '0, '0, '0));
    for (int i = 0; i < 150; i++) enqueue_cmd(random_cmd());
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0);
    // Hold the sender until the block has answered everything.
    hold_input = 1'b1;
    wait (!in_valid && expected_results.size() == 0);
    repeat (DRAIN_CYCLES / 10) @(posedge clk);
    hold_input = 1'b0;
    idle_free = 1'b1;
    for (int i = 0; i < 150; i++) enqueue_cmd(random_cmd());
    wait (pending_cmds.size() == 0);
    idle_free = 1'b0;
    for (int i = 0; i < 180; i++) enqueue_cmd(random_cmd());
    wait (pending_cmds.size() == 0 && !in_valid);
    inputs_done = 1'b1;
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d operations, %0d results, %0d expiries, %0d full-table rejects.",
             transfers_in, transfers_out, expiries, full_rejects);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (!hold_input && pending_cmds.size() > 0 &&
            (idle_free || $urandom_range(0, 99) >= 24)) begin
          in_valid <= 1'b1;
          in_operation <= pending_cmds[0].operation;
          in_group_id <= pending_cmds[0].group_id;
          in_timer_id <= pending_cmds[0].timer_id;
          in_timeout <= pending_cmds[0].timeout;
          in_job_tag <= pending_cmds[0].job_tag;
          void'(pending_cmds.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= idle_free ? 1'b0 : ($urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    bit moved;
    if (rst_n) begin
      moved = (in_valid && !in_stall) || (out_valid && !out_stall);
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_timer_events(cmd_t'({in_operation, in_group_id, in_timer_id, in_timeout,
                                     in_job_tag}));
        transfers_in <= transfers_in + 1;
      end
      if (out_valid && !out_stall) begin
        transfers_out <= transfers_out + 1;
        got = {out_kind, out_out_group, out_out_timer, out_out_tag, out_removed_count,
               out_last};
        if (got.kind == KIND_EXPIRED) expiries <= expiries + 1;
        if (got.kind == KIND_ADD_FULL) full_rejects <= full_rejects + 1;
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected transfer, got %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            $display("%0t: mismatch kind exp %0d got %0d, group exp %h got %h", $time,
                     want.kind, got.kind, want.grp, got.grp);
            $display("%0t:   timer exp %h got %h, tag exp %h got %h", $time, want.tmr,
                     got.tmr, want.tag, got.tag);
            $display("%0t:   count exp %0d got %0d, last exp %0d got %0d", $time,
                     want.cnt, got.cnt, want.last, got.last);
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end
endmodule
